[rtl/core/vkd_pkg.sv]
`default_nettype none

package vkd_pkg;

    // Codec mode register codes; the unused code behaves as H.264.
    localparam logic [1:0] CODEC_H264 = 2'd0;
    localparam logic [1:0] CODEC_HEVC = 2'd1;
    localparam logic [1:0] CODEC_AV1  = 2'd2;

    // Configuration port geometry: register i at byte address 4*i.
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam logic        REG_CODEC_MODE = 1'b0;

    // NAL header tests.
    localparam logic [4:0] NAL_IDR_TYPE  = 5'd5;
    localparam logic [5:0] HEVC_IRAP_LO  = 6'd16;
    localparam logic [5:0] HEVC_IRAP_HI  = 6'd23;

    // AV1 OBU header fields.
    localparam logic [3:0] OBU_SEQ_HEADER = 4'd1;

    // One parsing step handed to a parser.
    typedef struct packed {
        logic       en;
        logic       clr;
        logic [7:0] data;
    } t_step;

    // Verdict settled by a parser on this step.
    typedef struct packed {
        logic hit;
        logic key;
    } t_settle;

endpackage

`default_nettype wire

[rtl/core/vkd_if.sv]
`default_nettype none

interface vkd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface vkd_verdict_if;
    logic valid;
    logic ready;
    logic is_keyframe;

    modport source (output valid, output is_keyframe, input ready);
    modport sink   (input valid, input is_keyframe, output ready);
endinterface

`default_nettype wire

[rtl/core/vkd_apb_regs.sv]
`default_nettype none

module vkd_apb_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [vkd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [vkd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [vkd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [1:0]                      o_codec_mode
);

    logic [1:0] r_codec_mode;
    logic       w_sel_mode;

    assign pready     = 1'b1;
    assign w_sel_mode = (paddr[2] == vkd_pkg::REG_CODEC_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode <= vkd_pkg::CODEC_H264;
        end else if (psel && penable && pwrite && pready && w_sel_mode) begin
            r_codec_mode <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_mode) begin
            prdata = {{(vkd_pkg::CFG_DATA_W-2){1'b0}}, r_codec_mode};
        end
    end

    assign o_codec_mode = r_codec_mode;

endmodule

`default_nettype wire

[rtl/core/vkd_nal_parser.sv]
`default_nettype none

module vkd_nal_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire vkd_pkg::t_step   i_step,
    input  wire logic             i_hevc,
    output vkd_pkg::t_settle      o_settle
);

    logic [1:0] r_zero_run, n_zero_run;
    logic       r_hdr_next, n_hdr_next;
    logic [5:0] w_hevc_type;
    logic       w_key;

    assign w_hevc_type = i_step.data[6:1];
    assign w_key = i_hevc
        ? ((w_hevc_type >= vkd_pkg::HEVC_IRAP_LO) && (w_hevc_type <= vkd_pkg::HEVC_IRAP_HI))
        : (i_step.data[4:0] == vkd_pkg::NAL_IDR_TYPE);

    always_comb begin
        n_zero_run   = r_zero_run;
        n_hdr_next   = r_hdr_next;
        o_settle.hit = 1'b0;
        o_settle.key = 1'b0;
        if (i_step.en) begin
            if (r_hdr_next) begin
                n_hdr_next = 1'b0;
            end
            if (r_hdr_next && w_key) begin
                // keyframe header: settle, leave the zero run as it is
                o_settle.hit = 1'b1;
                o_settle.key = 1'b1;
            end else if (i_step.data == 8'h00) begin
                if (r_zero_run != 2'd2) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end else begin
                if (i_step.data == 8'h01 && r_zero_run == 2'd2) begin
                    n_hdr_next = 1'b1;
                end
                n_zero_run = 2'd0;
            end
        end
        if (i_step.clr) begin
            n_zero_run = 2'd0;
            n_hdr_next = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_hdr_next <= 1'b0;
        end else begin
            r_zero_run <= n_zero_run;
            r_hdr_next <= n_hdr_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/vkd_obu_parser.sv]
`default_nettype none

module vkd_obu_parser #(
    parameter int unsigned LEB_MAX_BYTES = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire vkd_pkg::t_step   i_step,
    output vkd_pkg::t_settle      o_settle
);

    localparam int unsigned AW = 7 * LEB_MAX_BYTES;
    localparam int unsigned CW = $clog2(LEB_MAX_BYTES + 1);

    typedef enum logic [1:0] {
        PH_HDR,
        PH_EXT,
        PH_SIZE,
        PH_SKIP
    } t_obu_phase;

    t_obu_phase  r_phase, n_phase;
    logic        r_seq, n_seq;
    logic        r_has_size, n_has_size;
    logic [AW-1:0] r_accum, n_accum;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_skip, n_skip;
    logic        w_hdr_done;
    logic        w_hd_seq;
    logic        w_hd_has;

    always_comb begin
        n_phase      = r_phase;
        n_seq        = r_seq;
        n_has_size   = r_has_size;
        n_accum      = r_accum;
        n_count      = r_count;
        n_skip       = r_skip;
        o_settle.hit = 1'b0;
        o_settle.key = 1'b0;
        w_hdr_done   = 1'b0;
        w_hd_seq     = r_seq;
        w_hd_has     = r_has_size;
        if (i_step.en) begin
            unique case (r_phase)
                PH_HDR: begin
                    if (i_step.data[7]) begin
                        // forbidden bit
                        o_settle.hit = 1'b1;
                    end else begin
                        n_seq      = (i_step.data[6:3] == vkd_pkg::OBU_SEQ_HEADER);
                        n_has_size = i_step.data[1];
                        w_hd_seq   = n_seq;
                        w_hd_has   = n_has_size;
                        if (i_step.data[2]) begin
                            n_phase = PH_EXT;
                        end else begin
                            w_hdr_done = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    w_hdr_done = 1'b1;
                end
                PH_SIZE: begin
                    for (int k = 0; k < LEB_MAX_BYTES; k++) begin
                        if (r_count == CW'(k)) begin
                            n_accum[7*k +: 7] = r_accum[7*k +: 7] | i_step.data[6:0];
                        end
                    end
                    n_count = r_count + CW'(1);
                    if (!i_step.data[7]) begin
                        n_skip  = n_accum;
                        n_phase = (n_accum == '0) ? PH_HDR : PH_SKIP;
                    end else if (n_count >= CW'(LEB_MAX_BYTES)) begin
                        // leb128 runs past its byte limit
                        o_settle.hit = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - AW'(1);
                    if (r_skip == AW'(1)) begin
                        n_phase = PH_HDR;
                    end
                end
                default: begin
                    n_phase = PH_HDR;
                end
            endcase
            if (w_hdr_done) begin
                if (w_hd_seq) begin
                    o_settle.hit = 1'b1;
                    o_settle.key = 1'b1;
                end else if (!w_hd_has) begin
                    o_settle.hit = 1'b1;
                end else begin
                    n_phase = PH_SIZE;
                    n_accum = '0;
                    n_count = '0;
                end
            end
        end
        if (i_step.clr) begin
            n_phase    = PH_HDR;
            n_seq      = 1'b0;
            n_has_size = 1'b0;
            n_accum    = '0;
            n_count    = '0;
            n_skip     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR;
            r_seq      <= 1'b0;
            r_has_size <= 1'b0;
            r_accum    <= '0;
            r_count    <= '0;
            r_skip     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_seq      <= n_seq;
            r_has_size <= n_has_size;
            r_accum    <= n_accum;
            r_count    <= n_count;
            r_skip     <= n_skip;
        end
    end

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != '0))
        else $error("payload skip phase entered with nothing left to skip");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIZE) |-> (r_count <= CW'(LEB_MAX_BYTES)))
        else $error("leb128 byte count beyond its limit");

endmodule

`default_nettype wire

[rtl/core/video_keyframe_detector.sv]
`default_nettype none

// Channel   Dir  Payload                     Handshake
// i_byte    in   data_byte[7:0], frame_end   valid/ready, request taken when both high
// o_verdict out  is_keyframe                 valid/ready, one request per frame
// APB cfg   in   codec_mode at address 0     psel/penable/pwrite, pready tied high
//
// One byte is taken every cycle while input ready is high. A taken byte is held
// in the input register; from there the parsers update their state and, on a
// frame-end byte, the verdict is loaded into the result register.
// Reset is synchronous and active low; it clears the parser state, both
// valid flags and codec_mode (H.264).
// A stalled verdict holds a frame-end byte in the input register, and input
// ready drops until the result register frees; other bytes keep flowing.

module video_keyframe_detector #(
    parameter int unsigned LEB_MAX_BYTES = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    vkd_byte_if.sink                             i_byte,
    vkd_verdict_if.source                        o_verdict,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [vkd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [vkd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [vkd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    logic [1:0]        w_mode;

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_data;
    logic              r_in_end;

    // result register
    logic              r_out_valid;
    logic              r_out_key;

    // shared verdict
    logic              r_found, n_found;
    logic              r_final, n_final;

    logic              w_out_free;
    logic              w_adv;
    logic              w_parse;
    logic              w_done;
    vkd_pkg::t_step    w_nal_step;
    vkd_pkg::t_step    w_obu_step;
    vkd_pkg::t_settle  w_nal_settle;
    vkd_pkg::t_settle  w_obu_settle;
    vkd_pkg::t_settle  w_settle;

    vkd_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_codec_mode (w_mode)
    );

    // Advance the held byte unless it ends a frame and the result slot is full and not being taken.
    assign w_out_free   = !r_out_valid || o_verdict.ready;
    assign w_adv        = r_in_valid && (!r_in_end || w_out_free);
    assign w_done       = w_adv && r_in_end;
    assign w_parse      = w_adv && !r_final;
    assign i_byte.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_data <= i_byte.data_byte;
            r_in_end  <= i_byte.frame_end;
        end
    end

    // Steer the byte to the parser of the mode in force; the other keeps its state, and frame end clears both.
    always_comb begin
        w_nal_step.en   = w_parse && (w_mode != vkd_pkg::CODEC_AV1);
        w_nal_step.clr  = w_done;
        w_nal_step.data = r_in_data;
        w_obu_step.en   = w_parse && (w_mode == vkd_pkg::CODEC_AV1);
        w_obu_step.clr  = w_done;
        w_obu_step.data = r_in_data;
    end

    vkd_nal_parser u_nal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_nal_step),
        .i_hevc   (w_mode == vkd_pkg::CODEC_HEVC),
        .o_settle (w_nal_settle)
    );

    vkd_obu_parser #(
        .LEB_MAX_BYTES (LEB_MAX_BYTES)
    ) u_obu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_obu_step),
        .o_settle (w_obu_settle)
    );

    // Only one parser is enabled at a time, so OR the settle flags.
    assign w_settle.hit = w_nal_settle.hit | w_obu_settle.hit;
    assign w_settle.key = (w_nal_settle.hit & w_nal_settle.key)
                        | (w_obu_settle.hit & w_obu_settle.key);

    always_comb begin
        n_found = w_settle.hit ? w_settle.key : r_found;
        n_final = r_final | w_settle.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_final <= 1'b0;
        end else if (w_done) begin
            // drop the verdict state at frame end
            r_found <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_found <= n_found;
            r_final <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_key <= n_found;
        end
    end

    assign o_verdict.valid       = r_out_valid;
    assign o_verdict.is_keyframe = r_out_key;

    a_verdict_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_out_valid)
        else $error("frame end did not load the result register");

    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (!r_found && !r_final))
        else $error("verdict state not cleared after frame end");

    a_end_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_end && r_out_valid && !o_verdict.ready) |-> !i_byte.ready)
        else $error("input taken while a frame end waits for the result slot");

endmodule

`default_nettype wire
